FILE: rtl/clw_pkg.sv
// ----------------------------------------------------------------------------
// clw_pkg
// Shared types, codes and constants of the 4-bit character LCD writer.
// ----------------------------------------------------------------------------
package clw_pkg;

   // item modes
   localparam logic [1:0] MODE_CMD      = 2'd0;
   localparam logic [1:0] MODE_DATA     = 2'd1;
   localparam logic [1:0] MODE_PWR_UP   = 2'd2;
   localparam logic [1:0] MODE_PWR_DOWN = 2'd3;

   // configuration register indexes
   localparam int          CSR_INDEX_W     = 3;
   localparam logic [2:0]  CSR_PULSE       = 3'd0;
   localparam logic [2:0]  CSR_GAP         = 3'd1;
   localparam logic [2:0]  CSR_BYTE_DELAY  = 3'd2;
   localparam logic [2:0]  CSR_CLEAR_DELAY = 3'd3;
   localparam logic [2:0]  CSR_POWERUP     = 3'd4;

   // register reset values
   localparam logic [15:0] PULSE_RESET       = 16'd1;
   localparam logic [15:0] GAP_RESET         = 16'd100;
   localparam logic [15:0] BYTE_DELAY_RESET  = 16'd200;
   localparam logic [15:0] CLEAR_DELAY_RESET = 16'd200;
   localparam logic [15:0] POWERUP_RESET     = 16'd2000;

   // init sequence timing
   localparam logic [15:0] INIT_BUSY_TICKS  = 16'd5;
   localparam logic [15:0] INIT_CLEAR_TICKS = 16'd400;
   localparam logic [7:0]  CLEAR_CMD        = 8'h01;
   localparam logic [2:0]  INIT_CLEAR_IDX   = 3'd3;
   localparam logic [2:0]  INIT_LAST_IDX    = 3'd5;
   localparam logic [1:0]  LAST_STEP        = 2'd3;

   // kind of pin state the controller asks for
   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_PWR_ON,
      EMIT_BYTE,
      EMIT_PWR_OFF
   } emit_kind_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] byte_value;
   } req_type;

   typedef struct packed {
      logic        power_pin;
      logic        select_pin;
      logic        strobe_pin;
      logic [3:0]  bus_nibble;
      logic [15:0] hold_ticks;
      logic        last_step;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic          load;
      logic          emit;
      emit_kind_type kind;
      logic [1:0]    step;
      logic          init;
      logic [2:0]    idx;
      logic          last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic powered;
      logic out_free;
   } stat_type;

   function automatic logic [7:0] init_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = 8'h02;
         3'd1:    b = 8'h28;
         3'd2:    b = 8'h0C;
         3'd3:    b = 8'h01;
         3'd4:    b = 8'h06;
         3'd5:    b = 8'h80;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[16] ? 16'hFFFF : s[15:0];
   endfunction

endpackage

FILE: rtl/clw_ctrl.sv
// ----------------------------------------------------------------------------
// clw_ctrl
// Sequencer: walks pin states of each word, one state per output slot.
// ----------------------------------------------------------------------------
module clw_ctrl
   import clw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_mode,
   output logic       req_stall,
   input  stat_type   stat,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PWR_ON,
      ST_BYTE,
      ST_PWR_OFF
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] step_ff, step_in;
   logic [2:0] idx_ff, idx_in;
   logic       init_ff, init_in;
   logic       advance;
   logic       ready;
   logic       accept;
   logic       pwr_now;

   // drive command from current state
   always_comb begin
      cmd.load = accept;
      cmd.emit = (state_ff != ST_IDLE);
      cmd.step = step_ff;
      cmd.init = init_ff;
      cmd.idx  = idx_ff;
      case (state_ff)
         ST_PWR_ON:  cmd.kind = EMIT_PWR_ON;
         ST_BYTE:    cmd.kind = EMIT_BYTE;
         ST_PWR_OFF: cmd.kind = EMIT_PWR_OFF;
         default:    cmd.kind = EMIT_NONE;
      endcase
      case (state_ff)
         ST_BYTE:    cmd.last = (step_ff == LAST_STEP) && (!init_ff || idx_ff == INIT_LAST_IDX);
         ST_PWR_OFF: cmd.last = 1'b1;
         default:    cmd.last = 1'b0;
      endcase
   end

   // hold the input off during reset and while a word still has states to go
   assign advance   = cmd.emit && stat.out_free;
   assign ready     = (state_ff == ST_IDLE) || (advance && cmd.last);
   assign req_stall = reset || !ready;
   assign accept    = req_valid && !req_stall;
   // power is dropping at this very edge when the off state goes out
   assign pwr_now   = stat.powered && (state_ff != ST_PWR_OFF);

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      idx_in   = idx_ff;
      init_in  = init_ff;
      if (advance) begin
         case (state_ff)
            ST_PWR_ON: begin
               state_in = ST_BYTE;
               step_in  = 2'd0;
               idx_in   = 3'd0;
               init_in  = 1'b1;
            end
            ST_BYTE: begin
               step_in = step_ff + 2'd1;
               if (step_ff == LAST_STEP) begin
                  if (cmd.last) begin
                     state_in = ST_IDLE;
                  end else begin
                     idx_in = idx_ff + 3'd1;
                  end
               end
            end
            default: state_in = ST_IDLE;
         endcase
      end
      if (accept) begin
         step_in = 2'd0;
         idx_in  = 3'd0;
         init_in = 1'b0;
         case (req_mode)
            MODE_CMD, MODE_DATA: state_in = ST_BYTE;
            MODE_PWR_UP:         state_in = pwr_now ? ST_IDLE : ST_PWR_ON;
            MODE_PWR_DOWN:       state_in = ST_PWR_OFF;
            default:             state_in = ST_IDLE;
         endcase
      end
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= 2'd0;
         idx_ff   <= 3'd0;
         init_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         idx_ff   <= idx_in;
         init_ff  <= init_in;
      end
   end

   a_off_one_state: assert property (@(posedge clock) disable iff (reset)
      accept && req_mode == MODE_PWR_DOWN |=> cmd.emit && cmd.last && cmd.kind == EMIT_PWR_OFF)
      else $error("power-down word did not give a single final state");

   a_skip_powered: assert property (@(posedge clock) disable iff (reset)
      accept && req_mode == MODE_PWR_UP && pwr_now |=> !cmd.emit)
      else $error("power-up while powered produced pin states");

   a_init_follows: assert property (@(posedge clock) disable iff (reset)
      advance && cmd.kind == EMIT_PWR_ON |=>
         cmd.kind == EMIT_BYTE && cmd.init && cmd.step == 2'd0 && cmd.idx == 3'd0)
      else $error("init sequence did not start after power state");

endmodule

FILE: rtl/clw_dpath.sv
// ----------------------------------------------------------------------------
// clw_dpath
// Registers, word latch, pin state forming and the output register.
// ----------------------------------------------------------------------------
module clw_dpath
   import clw_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]            csr_wr_data,
   input  req_type                req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_item,
   input  cmd_type                cmd,
   output stat_type               stat
);

   logic [15:0] pulse_ff, gap_ff, bdelay_ff, cdelay_ff, pwrup_ff;
   logic [15:0] base_ff;
   req_type     req_ff;
   logic        powered_ff, powered_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_item_ff, rsp_item_in;
   logic        out_free;
   logic [7:0]  cur_byte;
   logic [15:0] extra;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ff  <= PULSE_RESET;
         gap_ff    <= GAP_RESET;
         bdelay_ff <= BYTE_DELAY_RESET;
         cdelay_ff <= CLEAR_DELAY_RESET;
         pwrup_ff  <= POWERUP_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PULSE:       pulse_ff  <= csr_wr_data;
            CSR_GAP:         gap_ff    <= csr_wr_data;
            CSR_BYTE_DELAY:  bdelay_ff <= csr_wr_data;
            CSR_CLEAR_DELAY: cdelay_ff <= csr_wr_data;
            CSR_POWERUP:     pwrup_ff  <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // precompute gap+byte delay; user keeps registers still while a word runs
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= sat_add(GAP_RESET, BYTE_DELAY_RESET);
      end else begin
         base_ff <= sat_add(gap_ff, bdelay_ff);
      end
   end

   // latch accepted word
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_item;
      end
   end

   // form the pin state
   always_comb begin
      cur_byte = cmd.init ? init_byte(cmd.idx) : req_ff.byte_value;
      if (cmd.init) begin
         extra = (cmd.idx == INIT_CLEAR_IDX) ? INIT_CLEAR_TICKS : INIT_BUSY_TICKS;
      end else if (req_ff.mode == MODE_CMD && req_ff.byte_value == CLEAR_CMD) begin
         extra = cdelay_ff;
      end else begin
         extra = 16'd0;
      end
      rsp_item_in = '0;
      rsp_item_in.last_step = cmd.last;
      case (cmd.kind)
         EMIT_PWR_ON: begin
            rsp_item_in.power_pin  = 1'b1;
            rsp_item_in.hold_ticks = pwrup_ff;
         end
         EMIT_BYTE: begin
            rsp_item_in.power_pin  = powered_ff;
            rsp_item_in.select_pin = cmd.init ? 1'b0 : req_ff.mode[0];
            rsp_item_in.strobe_pin = !cmd.step[0];
            rsp_item_in.bus_nibble = cmd.step[1] ? cur_byte[3:0] : cur_byte[7:4];
            case (cmd.step)
               2'd1:      rsp_item_in.hold_ticks = gap_ff;
               LAST_STEP: rsp_item_in.hold_ticks = sat_add(base_ff, extra);
               default:   rsp_item_in.hold_ticks = pulse_ff;
            endcase
         end
         default: ;
      endcase
   end

   // advance power flag and output register
   always_comb begin
      powered_in   = powered_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = cmd.emit;
         if (cmd.emit && cmd.kind == EMIT_PWR_ON) begin
            powered_in = 1'b1;
         end
         if (cmd.emit && cmd.kind == EMIT_PWR_OFF) begin
            powered_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         powered_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         powered_ff   <= powered_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && cmd.emit) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_item      = rsp_item_ff;
   assign stat.powered  = powered_ff;
   assign stat.out_free = out_free;

   a_off_clears_power: assert property (@(posedge clock) disable iff (reset)
      out_free && cmd.emit && cmd.kind == EMIT_PWR_OFF |=> !powered_ff && rsp_valid_ff)
      else $error("power-down state did not clear power");

endmodule

FILE: rtl/char_lcd_4bit_writer.sv
// ----------------------------------------------------------------------------
// char_lcd_4bit_writer
// Character LCD writer over a 4-bit bus: words in, timed pin states out.
// ----------------------------------------------------------------------------
// Each input word yields a run of pin states, one per cycle into the output
// register: a command or data byte gives 4 states, a power-down gives 1, a
// power-up gives 25 (power state plus six init bytes), and a power-up while
// already powered gives none. The rate is set by the sequencer, which emits
// one pin state per cycle and takes the next word in the cycle its last state
// leaves; downstream stall holds it. Each state carries the ticks the pins
// must be held; the block itself does no tick counting.
module char_lcd_4bit_writer
   import clw_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]            csr_wr_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_item
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   clw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_item.mode),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath
   clw_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 4-bit character LCD writer.
// ----------------------------------------------------------------------------
// Words go in through a valid/stall channel in random bursts. At each
// accepted word, an in-bench model of the pin sequencer works out the pin
// states the word should produce. Those states are queued and then checked
// field by field against the result channel, which stalls on shifting
// patterns and, in one phase, for a long stretch. A short directed table
// runs first. Random phases follow, each under its own register setting:
// all zero, all ones, full range, small and near saturation.
// ----------------------------------------------------------------------------
module tb_top
   import clw_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int    PHASES      = 6;
   localparam int    PHASE_WORDS = 47;
   localparam int    IDLE_CYCLES = 8;
   localparam int    LONG_HOLD   = 400;
   localparam int    MAX_REPORTS = 40;
   localparam int    NUM_ROWS    = 18;
   localparam int    LIMIT_NS    = 2_000_000;

   localparam logic [7:0] LCD_INIT_SEQ [6] = '{8'h02, 8'h28, 8'h0C, 8'h01, 8'h06, 8'h80};
   localparam logic [CSR_INDEX_W-1:0] REG_ORDER [5] =
      '{CSR_PULSE, CSR_GAP, CSR_BYTE_DELAY, CSR_CLEAR_DELAY, CSR_POWERUP};

   // how a directed row gets its expectation
   typedef enum logic [1:0] {
      ROW_PREDICT,
      ROW_NONE,
      ROW_ONE
   } row_kind_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_pattern_type;

   typedef struct packed {
      req_type      word;
      row_kind_type kind;
      rsp_type      typed;
   } step_row_type;

   // power-down state: every pin low, nothing to hold
   localparam rsp_type ALL_LOW = '{1'b0, 1'b0, 1'b0, 4'h0, 16'h0, 1'b1};

   localparam step_row_type DIRECTED [NUM_ROWS] = '{
      '{'{MODE_PWR_DOWN, 8'h00}, ROW_ONE,     ALL_LOW},
      '{'{MODE_DATA,     8'hFF}, ROW_PREDICT, '0},
      '{'{MODE_CMD,      8'h00}, ROW_PREDICT, '0},
      '{'{MODE_CMD,      8'h01}, ROW_PREDICT, '0},
      '{'{MODE_PWR_UP,   8'h00}, ROW_PREDICT, '0},
      '{'{MODE_PWR_UP,   8'h00}, ROW_NONE,    '0},
      '{'{MODE_CMD,      8'h01}, ROW_PREDICT, '0},
      '{'{MODE_DATA,     8'h01}, ROW_PREDICT, '0},
      '{'{MODE_DATA,     8'h00}, ROW_PREDICT, '0},
      '{'{MODE_DATA,     8'hFF}, ROW_PREDICT, '0},
      '{'{MODE_CMD,      8'hFF}, ROW_PREDICT, '0},
      '{'{MODE_DATA,     8'hA5}, ROW_PREDICT, '0},
      '{'{MODE_CMD,      8'h5A}, ROW_PREDICT, '0},
      '{'{MODE_CMD,      8'h80}, ROW_PREDICT, '0},
      '{'{MODE_PWR_DOWN, 8'hFF}, ROW_ONE,     ALL_LOW},
      '{'{MODE_PWR_DOWN, 8'h00}, ROW_ONE,     ALL_LOW},
      '{'{MODE_PWR_UP,   8'hFF}, ROW_PREDICT, '0},
      '{'{MODE_DATA,     8'h3C}, ROW_PREDICT, '0}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [15:0]            csr_wr_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_item = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_item;

   // model copy of the registers and the power flag
   logic [15:0] pulse_ticks  = PULSE_RESET;
   logic [15:0] gap_ticks    = GAP_RESET;
   logic [15:0] byte_delay   = BYTE_DELAY_RESET;
   logic [15:0] clear_delay  = CLEAR_DELAY_RESET;
   logic [15:0] warmup_ticks = POWERUP_RESET;
   logic        lcd_powered  = 1'b0;

   rsp_type word_states [$];
   rsp_type pin_states_due [$];

   int  mismatches     = 0;
   int  states_checked = 0;
   int  words_sent     = 0;
   int  powerups       = 0;
   int  clears         = 0;
   int  settings_used  = 1;
   int  burst_left     = 0;
   bit  hold_wanted    = 1'b0;
   bit  hold_done      = 1'b0;

   char_lcd_4bit_writer u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // end the run if it hangs
   initial begin
      #(LIMIT_NS);
      $display("DONE: errors detected");
      $finish;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
   endtask

   function automatic logic [15:0] capped_sum(input logic [15:0] a, input logic [15:0] b);
      int unsigned s;
      s = int'(a) + int'(b);
      return (s > 32'hFFFF) ? 16'hFFFF : s[15:0];
   endfunction

   // add one pin state; power follows the current power flag
   task automatic add_pin_state(input logic sel, input logic strobe, input logic [3:0] nib,
                                input logic [15:0] hold);
      rsp_type s;
      s.power_pin  = lcd_powered;
      s.select_pin = sel;
      s.strobe_pin = strobe;
      s.bus_nibble = nib;
      s.hold_ticks = hold;
      s.last_step  = 1'b0;
      word_states.push_back(s);
   endtask

   // high nibble strobed, then low nibble; the last state carries the byte wait
   task automatic add_byte_states(input logic sel, input logic [7:0] b,
                                  input logic [15:0] extra);
      add_pin_state(sel, 1'b1, b[7:4], pulse_ticks);
      add_pin_state(sel, 1'b0, b[7:4], gap_ticks);
      add_pin_state(sel, 1'b1, b[3:0], pulse_ticks);
      add_pin_state(sel, 1'b0, b[3:0], capped_sum(capped_sum(gap_ticks, byte_delay), extra));
   endtask

   // work out the pin states one word produces, into word_states
   task automatic predict_pin_states(input req_type w);
      word_states.delete();
      case (w.mode)
         MODE_CMD, MODE_DATA: begin
            add_byte_states(w.mode == MODE_DATA, w.byte_value,
                            (w.mode == MODE_CMD && w.byte_value == CLEAR_CMD) ?
                            clear_delay : 16'h0000);
            if (w.mode == MODE_CMD && w.byte_value == CLEAR_CMD)
               clears++;
         end
         MODE_PWR_UP: begin
            // already powered: ignore
            if (!lcd_powered) begin
               lcd_powered = 1'b1;
               add_pin_state(1'b0, 1'b0, 4'h0, warmup_ticks);
               foreach (LCD_INIT_SEQ[k])
                  add_byte_states(1'b0, LCD_INIT_SEQ[k],
                                  (LCD_INIT_SEQ[k] == CLEAR_CMD) ?
                                  INIT_CLEAR_TICKS : INIT_BUSY_TICKS);
               powerups++;
            end
         end
         default: begin
            lcd_powered = 1'b0;
            add_pin_state(1'b0, 1'b0, 4'h0, 16'h0000);
         end
      endcase
      if (word_states.size() > 0)
         word_states[$].last_step = 1'b1;
   endtask

   // offer one word, predict at acceptance, then pace the next burst
   task automatic send_word(input req_type w, input row_kind_type kind, input rsp_type typed,
                            output int n_states);
      int gap;
      @(negedge clock);
      req_item  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      words_sent++;
      predict_pin_states(w);
      n_states = word_states.size();
      case (kind)
         ROW_PREDICT: foreach (word_states[k]) pin_states_due.push_back(word_states[k]);
         ROW_ONE:     pin_states_due.push_back(typed);
         default:     ;
      endcase
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      case (idx)
         CSR_PULSE:       pulse_ticks  = data;
         CSR_GAP:         gap_ticks    = data;
         CSR_BYTE_DELAY:  byte_delay   = data;
         CSR_CLEAR_DELAY: clear_delay  = data;
         CSR_POWERUP:     warmup_ticks = data;
         default:         ;
      endcase
   endtask

   // drop valid, wait for every expected state, then let the pipe empty
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pin_states_due.size() != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   // receiver: shifting stall patterns, one long hold-off on request
   initial begin : rsp_side
      stall_pattern_type pattern;
      int span;
      int hold_left;
      int tick;
      pattern   = STALL_NONE;
      span      = 0;
      hold_left = 0;
      tick      = 0;
      forever begin
         @(negedge clock);
         tick++;
         if (hold_wanted && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (span == 0) begin
            pattern = stall_pattern_type'($urandom_range(0, 3));
            span    = $urandom_range(32, 256);
         end
         span--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (pattern)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 4) < 3);
               default:     rsp_stall <= (tick % 3 == 0);
            endcase
         end
      end
   end

   // compare each accepted pin state with the oldest expected one
   always @(posedge clock) begin : pin_check
      rsp_type due;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pin_states_due.size() == 0) begin
            report_mismatch("unexpected pin state", int'(rsp_item), 0);
         end else begin
            due = pin_states_due.pop_front();
            states_checked++;
            if (rsp_item.power_pin !== due.power_pin)
               report_mismatch("power_pin", rsp_item.power_pin, due.power_pin);
            if (rsp_item.select_pin !== due.select_pin)
               report_mismatch("select_pin", rsp_item.select_pin, due.select_pin);
            if (rsp_item.strobe_pin !== due.strobe_pin)
               report_mismatch("strobe_pin", rsp_item.strobe_pin, due.strobe_pin);
            if (rsp_item.bus_nibble !== due.bus_nibble)
               report_mismatch("bus_nibble", rsp_item.bus_nibble, due.bus_nibble);
            if (rsp_item.hold_ticks !== due.hold_ticks)
               report_mismatch("hold_ticks", rsp_item.hold_ticks, due.hold_ticks);
            if (rsp_item.last_step !== due.last_step)
               report_mismatch("last_step", rsp_item.last_step, due.last_step);
         end
      end
   end

   initial begin : stimulus
      req_type     w;
      int          roll;
      int          n_states;
      int          counted;
      logic [15:0] setting [5];

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // directed table at reset register values
      foreach (DIRECTED[r])
         send_word(DIRECTED[r].word, DIRECTED[r].kind, DIRECTED[r].typed, n_states);
      settle();

      for (int ph = 0; ph < PHASES; ph++) begin
         // reprogram every register while idle, plus one write off the map
         foreach (setting[r]) begin
            case (ph)
               0:       setting[r] = 16'h0000;
               1:       setting[r] = 16'hFFFF;
               3:       setting[r] = 16'($urandom_range(0, 40));
               4:       setting[r] = 16'($urandom_range(60000, 65535));
               default: setting[r] = 16'($urandom);
            endcase
            write_reg(REG_ORDER[r], setting[r]);
         end
         write_reg(CSR_INDEX_W'(CSR_POWERUP + 1 + $urandom_range(0, 2)), 16'($urandom));
         @(negedge clock);
         csr_wr_en <= 1'b0;
         settings_used++;

         // hold the receiver off while words keep coming
         if (ph == 2)
            hold_wanted = 1'b1;

         counted = 0;
         while (counted < PHASE_WORDS) begin
            roll = $urandom_range(0, 99);
            w.mode = (roll < 42) ? MODE_CMD :
                     (roll < 84) ? MODE_DATA :
                     (roll < 93) ? MODE_PWR_UP : MODE_PWR_DOWN;
            w.byte_value = (w.mode == MODE_CMD && $urandom_range(0, 7) == 0) ?
                           CLEAR_CMD : 8'($urandom_range(0, 255));
            send_word(w, ROW_PREDICT, '0, n_states);
            if (n_states > 0)
               counted++;
         end
         settle();
      end

      $display("Covered %0d words under %0d register settings: %0d power-ups, %0d clears.",
               words_sent, settings_used, powerups, clears);
      $display("Checked %0d pin states, with one long receiver hold-off.", states_checked);
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: files.f
rtl/clw_pkg.sv
rtl/clw_ctrl.sv
rtl/clw_dpath.sv
rtl/char_lcd_4bit_writer.sv
verif/tb_top.sv
